FILE: design/selective_repeat_sender_window_top_defines.svh
// Assertion macros shared by the selective-repeat sender window RTL.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, masked while rst_n is low.
`define SRSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, masked while rst_n is low.
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
`default_nettype none

package srsw_pkg;

    localparam int MAX_PACKETS = 64;
    localparam int IDX_W       = $clog2(MAX_PACKETS);
    localparam int PTR_W       = $clog2(MAX_PACKETS + 1);

    localparam int SEQ_W       = 6;
    localparam int AGE_W       = 16;
    localparam int CREDIT_W    = 6;
    localparam int WIN_W       = 6;
    localparam int TOTAL_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [AGE_W-1:0]    AGE_MAX    = '1;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

    localparam logic [WIN_W-1:0]   WINDOW_RST  = WIN_W'(4);
    localparam logic [AGE_W-1:0]   TIMEOUT_RST = AGE_W'(50);
    localparam logic [TOTAL_W-1:0] TOTAL_RST   = TOTAL_W'(6);

    // Marks are checked this many at a time.
    localparam int MARK_GROUP = 8;
    localparam int MARK_STEPS = (MAX_PACKETS + MARK_GROUP - 1) / MARK_GROUP;
    localparam int GRP_W      = (MARK_STEPS > 1) ? $clog2(MARK_STEPS) : 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = CFG_IDX_W'(2);

    localparam logic OP_ACK  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic do_age;   // entry lies in [base, next)
        logic marked;   // entry already acknowledged
        logic armed;    // no timeout found yet on this tick
    } age_ctl_t;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             expired;
    } age_res_t;

endpackage

`default_nettype wire

FILE: design/srsw_age_mem.sv
// Per-packet age memory, one write and one registered read port, zero until written.
`default_nettype none

module srsw_age_mem
    import srsw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [AGE_W-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [AGE_W-1:0] rd_data
);

    logic [AGE_W-1:0]       mem [MAX_PACKETS];
    logic [MAX_PACKETS-1:0] vld_reg;
    logic [AGE_W-1:0]       rd_raw_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

FILE: design/srsw_age_unit.sv
// Shared age step: saturating increment and timeout compare for one entry.
`default_nettype none

module srsw_age_unit
    import srsw_pkg::*;
(
    input  wire logic [AGE_W-1:0] age_in,
    input  wire logic [AGE_W-1:0] timeout,
    input  wire age_ctl_t         ctl,
    output age_res_t              res
);

    logic [AGE_W-1:0] aged;

    always_comb
    begin
        aged = age_in;
        if (ctl.do_age && (age_in != AGE_MAX))
        begin
            aged = age_in + AGE_W'(1);
        end
        res.age     = aged;
        res.expired = ctl.armed && !ctl.marked && (aged > timeout);
    end

endmodule

`default_nettype wire

FILE: design/selective_repeat_sender_window_top.sv
// Flow: an acknowledgement beat passes S_ACK, the S_CHECK mark walk and S_FINISH; a tick
// beat passes S_SEND, S_CHECK, then, when it ages, S_SCAN over entries 0..next_to_send-1,
// and S_FINISH. Throughput: one beat at a time; the age scan walks one entry per cycle
// through the shared age unit and the age memory.
// Reset: async active low; marks cleared, ages read zero, base and next zero,
// credit 4, window 4, timeout 50, total 6. No clearing pass, the block is ready at once.
`default_nettype none

`include "selective_repeat_sender_window_top_defines.svh"

module selective_repeat_sender_window_top
    import srsw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // input beats
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    input  wire logic [SEQ_W-1:0]      ack_seq,

    // result beats
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       send_valid,
    output logic      [SEQ_W-1:0]      send_seq,
    output logic                       timeout_valid,
    output logic      [SEQ_W-1:0]      timeout_seq,
    output logic                       all_done,

    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // S_ACK    : apply the acknowledgement to marks, base and credit
    // S_SEND   : tick send step (skip a received packet or send one)
    // S_CHECK  : walk the marks MARK_GROUP at a time for all_done
    // S_SCAN   : walk entries 0..next-1 one per cycle, age those from base up, find the first timeout
    // S_FINISH : park the result until the output register is free
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_SEND,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [WIN_W-1:0]   cfg_window_reg,  cfg_window_next;
    logic [AGE_W-1:0]   cfg_timeout_reg, cfg_timeout_next;
    logic [TOTAL_W-1:0] cfg_total_reg,   cfg_total_next;

    // window state
    logic [MAX_PACKETS-1:0] marks_reg,  marks_next;
    logic [PTR_W-1:0]       base_reg,   base_next;
    logic [PTR_W-1:0]       nts_reg,    nts_next;
    logic [CREDIT_W-1:0]    credit_reg, credit_next;

    // latched beat and working result
    logic             op_reg,   op_next;
    logic [SEQ_W-1:0] seq_reg,  seq_next;
    logic             skip_reg, skip_next;
    logic             sv_reg,   sv_next;
    logic [SEQ_W-1:0] ss_reg,   ss_next;
    logic             tv_reg,   tv_next;
    logic [SEQ_W-1:0] ts_reg,   ts_next;

    // mark check sequencer
    logic [GRP_W-1:0] grp_reg,    grp_next;
    logic             chk_ok_reg, chk_ok_next;

    // age scan sequencer: read issued one cycle, processed the next
    logic [PTR_W-1:0] rd_idx_reg,   rd_idx_next;
    logic [PTR_W-1:0] scan_end_reg, scan_end_next;
    logic             p_vld_reg,    p_vld_next;
    logic [IDX_W-1:0] p_idx_reg,    p_idx_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             o_sv_reg,      o_sv_next;
    logic [SEQ_W-1:0] o_ss_reg,      o_ss_next;
    logic             o_tv_reg,      o_tv_next;
    logic [SEQ_W-1:0] o_ts_reg,      o_ts_next;
    logic             o_done_reg,    o_done_next;

    logic [PTR_W-1:0] limit;
    logic             in_fire;
    logic             grp_ok;

    // age memory and shared age unit
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [AGE_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [AGE_W-1:0] mem_rd_data;
    age_ctl_t         unit_ctl;
    age_res_t         unit_res;

    srsw_age_mem u_age_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    srsw_age_unit u_age_unit (
        .age_in  (mem_rd_data),
        .timeout (cfg_timeout_reg),
        .ctl     (unit_ctl),
        .res     (unit_res)
    );

    // Packets in play: total_packets clipped to the table depth.
    assign limit = (32'(cfg_total_reg) > MAX_PACKETS) ? PTR_W'(MAX_PACKETS)
                                                      : PTR_W'(cfg_total_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // AND of the marks in the current group that lie below the limit.
    always_comb
    begin
        int               k;
        logic [IDX_W-1:0] kidx;
        grp_ok = 1'b1;
        for (int j = 0; j < MARK_GROUP; j++)
        begin
            k    = int'(grp_reg) * MARK_GROUP + j;
            kidx = IDX_W'(k);
            if ((k < MAX_PACKETS) && (k < int'(limit)))
            begin
                grp_ok = grp_ok & marks_reg[kidx];
            end
        end
    end

    // Scan entry in flight: age only inside [base, next), time out only once.
    always_comb
    begin
        unit_ctl.do_age = (PTR_W'(p_idx_reg) >= base_reg);
        unit_ctl.marked = marks_reg[p_idx_reg];
        unit_ctl.armed  = !tv_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        cfg_window_next  = cfg_window_reg;
        cfg_timeout_next = cfg_timeout_reg;
        cfg_total_next   = cfg_total_reg;
        marks_next       = marks_reg;
        base_next        = base_reg;
        nts_next         = nts_reg;
        credit_next      = credit_reg;
        op_next          = op_reg;
        seq_next         = seq_reg;
        skip_next        = skip_reg;
        sv_next          = sv_reg;
        ss_next          = ss_reg;
        tv_next          = tv_reg;
        ts_next          = ts_reg;
        grp_next         = grp_reg;
        chk_ok_next      = chk_ok_reg;
        rd_idx_next      = rd_idx_reg;
        scan_end_next    = scan_end_reg;
        p_vld_next       = 1'b0;
        p_idx_next       = p_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        o_sv_next        = o_sv_reg;
        o_ss_next        = o_ss_reg;
        o_tv_next        = o_tv_reg;
        o_ts_next        = o_ts_reg;
        o_done_next      = o_done_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = p_idx_reg;
        mem_wr_data      = unit_res.age;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = rd_idx_reg[IDX_W-1:0];

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW:  cfg_window_next  = cfg_data[WIN_W-1:0];
                REG_TIMEOUT: cfg_timeout_next = cfg_data[AGE_W-1:0];
                REG_TOTAL:   cfg_total_next   = cfg_data[TOTAL_W-1:0];
                default:     ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = operation;
                    seq_next   = ack_seq;
                    skip_next  = 1'b0;
                    sv_next    = 1'b0;
                    ss_next    = '0;
                    tv_next    = 1'b0;
                    ts_next    = '0;
                    state_next = (operation == OP_TICK) ? S_SEND : S_ACK;
                end
            end

            S_ACK:
            begin
                if (32'(seq_reg) < 32'(limit))
                begin
                    marks_next[IDX_W'(seq_reg)] = 1'b1;
                    if (32'(seq_reg) == 32'(base_reg))
                    begin
                        base_next = base_reg + PTR_W'(1);
                        if (credit_reg != CREDIT_MAX)
                        begin
                            credit_next = credit_reg + CREDIT_W'(1);
                        end
                    end
                end
                grp_next    = '0;
                chk_ok_next = 1'b1;
                state_next  = S_CHECK;
            end

            S_SEND:
            begin
                if ((credit_reg != '0) && (nts_reg < limit))
                begin
                    if (marks_reg[IDX_W'(nts_reg)])
                    begin
                        skip_next = 1'b1;
                    end
                    else
                    begin
                        // fresh send restarts the packet's age
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = IDX_W'(nts_reg);
                        mem_wr_data = '0;
                        sv_next     = 1'b1;
                        ss_next     = SEQ_W'(nts_reg);
                        credit_next = credit_reg - CREDIT_W'(1);
                    end
                    nts_next = nts_reg + PTR_W'(1);
                end
                grp_next    = '0;
                chk_ok_next = 1'b1;
                state_next  = S_CHECK;
            end

            S_CHECK:
            begin
                chk_ok_next = chk_ok_reg & grp_ok;
                grp_next    = grp_reg + GRP_W'(1);
                if (grp_reg == GRP_W'(MARK_STEPS - 1))
                begin
                    if ((op_reg == OP_TICK) && !skip_reg && !(chk_ok_reg & grp_ok))
                    begin
                        rd_idx_next   = '0;
                        scan_end_next = nts_reg;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN:
            begin
                if (p_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = p_idx_reg;
                    mem_wr_data = unit_res.age;
                    if (unit_res.expired)
                    begin
                        tv_next     = 1'b1;
                        ts_next     = SEQ_W'(p_idx_reg);
                        credit_next = CREDIT_W'(cfg_window_reg);
                        nts_next    = PTR_W'(p_idx_reg);
                    end
                end
                if (rd_idx_reg < scan_end_reg)
                begin
                    mem_rd_en   = 1'b1;
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + PTR_W'(1);
                end
                else if (!p_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_sv_next      = sv_reg;
                    o_ss_next      = ss_reg;
                    o_tv_next      = tv_reg;
                    o_ts_next      = ts_reg;
                    o_done_next    = chk_ok_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cfg_window_reg  <= WINDOW_RST;
            cfg_timeout_reg <= TIMEOUT_RST;
            cfg_total_reg   <= TOTAL_RST;
            marks_reg       <= '0;
            base_reg        <= '0;
            nts_reg         <= '0;
            credit_reg      <= CREDIT_W'(WINDOW_RST);
            op_reg          <= OP_ACK;
            seq_reg         <= '0;
            skip_reg        <= 1'b0;
            sv_reg          <= 1'b0;
            ss_reg          <= '0;
            tv_reg          <= 1'b0;
            ts_reg          <= '0;
            grp_reg         <= '0;
            chk_ok_reg      <= 1'b1;
            rd_idx_reg      <= '0;
            scan_end_reg    <= '0;
            p_vld_reg       <= 1'b0;
            p_idx_reg       <= '0;
            out_valid_reg   <= 1'b0;
            o_sv_reg        <= 1'b0;
            o_ss_reg        <= '0;
            o_tv_reg        <= 1'b0;
            o_ts_reg        <= '0;
            o_done_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_window_reg  <= cfg_window_next;
            cfg_timeout_reg <= cfg_timeout_next;
            cfg_total_reg   <= cfg_total_next;
            marks_reg       <= marks_next;
            base_reg        <= base_next;
            nts_reg         <= nts_next;
            credit_reg      <= credit_next;
            op_reg          <= op_next;
            seq_reg         <= seq_next;
            skip_reg        <= skip_next;
            sv_reg          <= sv_next;
            ss_reg          <= ss_next;
            tv_reg          <= tv_next;
            ts_reg          <= ts_next;
            grp_reg         <= grp_next;
            chk_ok_reg      <= chk_ok_next;
            rd_idx_reg      <= rd_idx_next;
            scan_end_reg    <= scan_end_next;
            p_vld_reg       <= p_vld_next;
            p_idx_reg       <= p_idx_next;
            out_valid_reg   <= out_valid_next;
            o_sv_reg        <= o_sv_next;
            o_ss_reg        <= o_ss_next;
            o_tv_reg        <= o_tv_next;
            o_ts_reg        <= o_ts_next;
            o_done_reg      <= o_done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_valid    = o_sv_reg;
    assign send_seq      = o_ss_reg;
    assign timeout_valid = o_tv_reg;
    assign timeout_seq   = o_ts_reg;
    assign all_done      = o_done_reg;

    // A finished transfer never ages, so it cannot report a timeout.
    `SRSW_ASSERT_NOW(a_done_no_timeout, out_valid && all_done, !timeout_valid, "timeout on a finished transfer")
    // Scan write-back and the next read always hit different entries.
    `SRSW_ASSERT_NOW(a_mem_no_clash, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "age memory read/write clash")
    // Pipelined scan data is only in flight while scanning.
    `SRSW_ASSERT_NOW(a_pipe_in_scan, p_vld_reg, state_reg == S_SCAN, "scan data outside scan")
    // An accepted beat holds off the next one: the input is stalled once it is taken.
    `SRSW_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall, "input not stalled after accept")

endmodule

`default_nettype wire

FILE: dv/selective_repeat_sender_window_top_tb.sv
// Self-checking testbench for the selective-repeat sender window: directed and random beats.
`default_nettype none

module selective_repeat_sender_window_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsw_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 8;
    // Slowest tick runs a full age scan; add long sender gaps, long receiver stalls
    // and the forced hold-off, then take it several times over.
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 215;

    // Index with no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] send_seq;
        logic             timeout_valid;
        logic [SEQ_W-1:0] timeout_seq;
        logic             all_done;
    } window_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  operation     = OP_ACK;
    logic [SEQ_W-1:0]      ack_seq       = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  send_valid;
    logic [SEQ_W-1:0]      send_seq;
    logic                  timeout_valid;
    logic [SEQ_W-1:0]      timeout_seq;
    logic                  all_done;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    selective_repeat_sender_window_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .ack_seq       (ack_seq),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .send_valid    (send_valid),
        .send_seq      (send_seq),
        .timeout_valid (timeout_valid),
        .timeout_seq   (timeout_seq),
        .all_done      (all_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window model: shadow registers and per-packet state.
    // ------------------------------------------------------------------
    int window_reg  = WINDOW_RST;
    int timeout_reg = TIMEOUT_RST;
    int total_reg   = TOTAL_RST;

    bit acked  [MAX_PACKETS];
    int age_of [MAX_PACKETS];
    int base_ptr = 0;
    int next_ptr = 0;
    int credit   = WINDOW_RST;

    window_result_t pending_results[$];
    int mismatch_count = 0;
    int results_seen   = 0;
    int cycle_count    = 0;

    // Sender runs gap-free while this is set.
    bit sender_steady = 1'b0;

    // Bumped by a test to ask the receiver for one long hold-off.
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int stall_left = 0;

    function automatic int packet_limit();
        return (total_reg > MAX_PACKETS) ? MAX_PACKETS : total_reg;
    endfunction

    function automatic bit all_acked();
        int lim;
        lim = packet_limit();
        for (int i = 0; i < lim; i++)
            if (!acked[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Applies one beat to the window model and returns the result it should produce.
    function automatic window_result_t predict_window_beat(input logic op,
                                                           input logic [SEQ_W-1:0] seq);
        window_result_t r;
        int             lim;
        bit             skipped;
        bit             found;
        int             i;
        r       = '0;
        lim     = packet_limit();
        skipped = 1'b0;
        if (op == OP_ACK)
        begin
            // Out-of-range acks fall through untouched.
            if (seq < lim)
            begin
                acked[seq] = 1'b1;
                // Only the base slides; earlier out-of-order marks don't drag it along.
                if (seq == base_ptr)
                begin
                    base_ptr = (base_ptr + 1) & 'h7F;
                    if (credit < CREDIT_MAX)
                        credit++;
                end
            end
        end
        else
        begin
            if (credit > 0 && next_ptr < lim)
            begin
                if (acked[next_ptr])
                    skipped = 1'b1;
                else
                begin
                    age_of[next_ptr] = 0;
                    r.send_valid     = 1'b1;
                    r.send_seq       = next_ptr[SEQ_W-1:0];
                    credit--;
                end
                next_ptr++;
            end
            if (!skipped && !all_acked())
            begin
                for (i = base_ptr; i < next_ptr && i < MAX_PACKETS; i++)
                    if (age_of[i] < AGE_MAX)
                        age_of[i]++;
                found = 1'b0;
                // Lowest expired unacked packet wins and rewinds the pointer.
                for (i = 0; i < next_ptr && i < MAX_PACKETS && !found; i++)
                begin
                    if (!acked[i] && age_of[i] > timeout_reg)
                    begin
                        r.timeout_valid = 1'b1;
                        r.timeout_seq   = i[SEQ_W-1:0];
                        credit          = window_reg;
                        next_ptr        = i;
                        found           = 1'b1;
                    end
                end
            end
        end
        r.all_done = all_acked();
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d, cycle %0d)",
                 field, got, want, results_seen, cycle_count);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Drivers. Called right after a rising edge; valid stays up between
    // back-to-back beats so it is never dropped and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic op, input logic [SEQ_W-1:0] seq);
        int gap;
        in_valid  <= 1'b1;
        operation <= op;
        ack_seq   <= seq;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_window_beat(op, seq));
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WINDOW)
            window_reg = data & 'h3F;
        else if (idx == REG_TIMEOUT)
            timeout_reg = data;
        else if (idx == REG_TOTAL)
            total_reg = data & 'h7F;
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_window_regs(input logic [CFG_DATA_W-1:0] win,
                                   input logic [CFG_DATA_W-1:0] tmo,
                                   input logic [CFG_DATA_W-1:0] tot);
        write_reg(REG_WINDOW, win, 1'b0);
        write_reg(REG_TIMEOUT, tmo, 1'b0);
        write_reg(REG_TOTAL, tot, 1'b1);
    endtask

    // Drop valid, let every expected result come back, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic tick();
        send_beat(OP_TICK, SEQ_W'($urandom));
    endtask

    task automatic ack(input int seq);
        send_beat(OP_ACK, SEQ_W'(seq));
    endtask

    // One random beat, shaped by the model's current window so a share of acks lands
    // on packets in flight or the base; the rest are in-range, out-of-range and plain noise.
    task automatic random_beat();
        int               lim;
        int               r;
        logic [SEQ_W-1:0] seq;
        int               in_flight[$];
        lim = packet_limit();
        if ($urandom_range(0, 99) < 70)
            tick();
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                for (int i = base_ptr; i < next_ptr && i < lim; i++)
                    if (!acked[i])
                        in_flight.push_back(i);
                if (in_flight.size() > 0)
                    seq = SEQ_W'(in_flight[$urandom_range(0, in_flight.size() - 1)]);
                else
                    seq = base_ptr[SEQ_W-1:0];
            end
            else if (r < 40)
                seq = base_ptr[SEQ_W-1:0];
            else if (r < 60 && lim > 0)
                seq = SEQ_W'($urandom_range(0, lim - 1));
            else if (r < 80 && lim < MAX_PACKETS)
                seq = SEQ_W'($urandom_range(lim, MAX_PACKETS - 1));
            else
                seq = SEQ_W'($urandom);
            send_beat(OP_ACK, seq);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: window 4, timeout 50, six packets. Walks a whole transfer
    // with an out-of-range ack, a skip over a pre-acked packet, an out-of-order
    // ack that leaves the base where it is, and the final all-done beat.
    task automatic test_default_walk();
        ack(MAX_PACKETS - 1);
        ack(0);
        tick();
        tick();
        ack(3);
        ack(1);
        tick();
        tick();
        tick();
        tick();
        tick();
        ack(2);
        ack(4);
        ack(5);
        tick();
        wait_drained();
    endtask

    // Empty transfer reads as done; then zero window with zero timeout, so the
    // first send expires at once and nothing moves until the base is acked.
    task automatic test_zero_cases();
        write_reg(REG_TOTAL, '0, 1'b1);
        tick();
        ack(0);
        wait_drained();
        set_window_regs('0, '0, 10);
        tick();
        tick();
        ack(3);
        tick();
        wait_drained();
    endtask

    // Full window restored by a timeout, then a base ack must not push the
    // credit past its ceiling.
    task automatic test_credit_saturation();
        write_reg(REG_WINDOW, 63, 1'b1);
        ack(4);
        tick();
        ack(5);
        wait_drained();
    endtask

    // Write to the unused index is dropped; longest timeout goes in alongside.
    task automatic test_spare_register();
        write_reg(REG_SPARE, '1, 1'b0);
        write_reg(REG_TIMEOUT, '1, 1'b1);
        tick();
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so the block fills and has to stall its input.
    task automatic test_backpressure();
        set_window_regs(8, 30, 16);
        sender_steady = 1'b1;
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 5 == 4)
                ack(base_ptr);
            else
                tick();
        end
        sender_steady = 1'b0;
        wait_drained();
    endtask

    // Transfers of growing size, one shrunk on purpose; pointers carry over
    // between phases. On odd phases the window and total writes carry junk in the unused bits.
    task automatic test_random_transfers();
        int                    tot;
        logic [CFG_DATA_W-1:0] win;
        logic [CFG_DATA_W-1:0] tmo;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: tot = 12;
                1: tot = 20;
                2: tot = 5;
                3: tot = 28;
                4: tot = 36;
                5: tot = 48;
                6: tot = 64;
                default: tot = 127;
            endcase
            if (p == 2)
                win = 63;
            else if (p == 3)
                win = 1;
            else if (p == 4)
                win = 32;
            else
                win = $urandom_range(1, 32);
            tmo = (p == 5) ? '1 : CFG_DATA_W'($urandom_range(0, 40));
            if (p % 2 == 1)
            begin
                win = win | CFG_DATA_W'($urandom_range(0, 1023) << 6);
                tot = tot | ($urandom_range(0, 511) << 7);
            end
            set_window_regs(win, tmo, CFG_DATA_W'(tot));
            sender_steady = (p % 3 == 1);
            repeat (ITEMS_PER_PHASE) random_beat();
            sender_steady = 1'b0;
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern, then check every accepted beat in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_asked != hold_taken)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = pick_gap(1'b0);
        end
        else
        begin
            // Now and then a long run with no stall at all.
            out_stall  <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 8);
        end
    end

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (send_valid !== want.send_valid)
                    report_mismatch("send_valid", send_valid, want.send_valid);
                if (send_seq !== want.send_seq)
                    report_mismatch("send_seq", send_seq, want.send_seq);
                if (timeout_valid !== want.timeout_valid)
                    report_mismatch("timeout_valid", timeout_valid, want.timeout_valid);
                if (timeout_seq !== want.timeout_seq)
                    report_mismatch("timeout_seq", timeout_seq, want.timeout_seq);
                if (all_done !== want.all_done)
                    report_mismatch("all_done", all_done, want.all_done);
            end
            results_seen++;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("selective_repeat_sender_window_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_walk();
        test_zero_cases();
        test_credit_saturation();
        test_spare_register();
        test_backpressure();
        test_random_transfers();
        wait_drained();
        if (mismatch_count == 0)
            $display("selective_repeat_sender_window_top_tb: done, clean");
        else
            $display("selective_repeat_sender_window_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
